// File: sv/iou_trk_pkg.sv
package iou_trk_pkg;

   localparam int MAX_TRACKS          = 32;
   localparam int MAX_BOXES_PER_FRAME = 32;

   localparam int TRK_IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int TRK_CNT_W = $clog2(MAX_TRACKS + 1);
   localparam int PND_IDX_W = (MAX_BOXES_PER_FRAME > 1) ? $clog2(MAX_BOXES_PER_FRAME) : 1;
   localparam int PND_CNT_W = $clog2(MAX_BOXES_PER_FRAME + 1);
   // scan visits every track, then lets the pipeline drain
   localparam int SCAN_LEN  = MAX_TRACKS + 4;
   localparam int SEQ_CNT_W = $clog2(SCAN_LEN + MAX_BOXES_PER_FRAME + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_IOU_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MISSED    = 2'd1;

   localparam logic [16:0] THR_DEFAULT  = 17'd19661;
   localparam logic [16:0] THR_ONE      = 17'd65536;
   localparam logic [7:0]  MISS_DEFAULT = 8'd5;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic [7:0]  misses;
      logic [31:0] ident;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] width;
      logic [15:0] height;
   } trk_entry_type;

   typedef struct packed {
      logic shift;
      logic wr;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_AGE,
      ST_APPEND
   } seq_state_type;

endpackage

// File: sv/iou_trk_if.sv
interface iou_trk_req_if;
   logic        valid;
   logic        ready;
   logic        has_box;
   logic [15:0] box_left;
   logic [15:0] box_top;
   logic [15:0] box_width;
   logic [15:0] box_height;
   logic        frame_end;

   modport source (output valid, has_box, box_left, box_top, box_width, box_height,
                   frame_end, input ready);
   modport sink   (input valid, has_box, box_left, box_top, box_width, box_height,
                   frame_end, output ready);
endinterface

interface iou_trk_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] face_id;
   logic        new_track;

   modport source (output valid, face_id, new_track, input ready);
   modport sink   (input valid, face_id, new_track, output ready);
endinterface

// File: sv/iou_trk_cell.sv
module iou_trk_cell
   import iou_trk_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  trk_entry_type shift_in,
   input  trk_entry_type wr_data,
   output trk_entry_type entry
);

   trk_entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.wr) begin
         entry_in = wr_data;
      end else if (ctl.shift) begin
         entry_in = shift_in;
      end
      if (reset) begin
         entry_in.valid = 1'b0;
         entry_in.hit   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: sv/iou_trk_eval.sv
module iou_trk_eval
   import iou_trk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 cand_valid,
   input  logic [TRK_IDX_W-1:0] cand_idx,
   input  trk_entry_type        cand,
   input  logic [15:0]          box_left,
   input  logic [15:0]          box_top,
   input  logic [15:0]          box_width,
   input  logic [15:0]          box_height,
   input  logic [16:0]          threshold,
   output logic                 found,
   output logic [TRK_IDX_W-1:0] best_idx,
   output logic [31:0]          best_ident
);

   // stage 1: overlap extents
   logic                 s1_vld_ff;
   logic [TRK_IDX_W-1:0] s1_idx_ff;
   logic [31:0]          s1_id_ff;
   logic [16:0]          s1_iw_ff, s1_ih_ff;
   logic [15:0]          s1_tw_ff, s1_th_ff;
   // stage 2: areas
   logic                 s2_vld_ff;
   logic [TRK_IDX_W-1:0] s2_idx_ff;
   logic [31:0]          s2_id_ff;
   logic [33:0]          s2_inter_ff;
   logic [31:0]          s2_at_ff, s2_ab_ff;
   // stage 3: union
   logic                 s3_vld_ff;
   logic [TRK_IDX_W-1:0] s3_idx_ff;
   logic [31:0]          s3_id_ff;
   logic [31:0]          s3_inter_ff;
   logic [32:0]          s3_uni_ff;
   // running best
   logic                 found_ff;
   logic [TRK_IDX_W-1:0] best_idx_ff;
   logic [31:0]          best_id_ff;
   logic [31:0]          best_i_ff;
   logic [32:0]          best_u_ff;

   logic [16:0] x1, y1, x2, y2, r_b, r_t, b_b, b_t;
   logic [64:0] p_new, p_old;
   logic [49:0] p_thr;
   logic [47:0] inter_sh;
   logic        take;

   always_comb begin
      x1  = (box_left > cand.left) ? {1'b0, box_left} : {1'b0, cand.left};
      y1  = (box_top > cand.top) ? {1'b0, box_top} : {1'b0, cand.top};
      r_b = {1'b0, box_left} + {1'b0, box_width};
      r_t = {1'b0, cand.left} + {1'b0, cand.width};
      b_b = {1'b0, box_top} + {1'b0, box_height};
      b_t = {1'b0, cand.top} + {1'b0, cand.height};
      x2  = (r_b < r_t) ? r_b : r_t;
      y2  = (b_b < b_t) ? b_b : b_t;
   end

   always_comb begin
      p_new    = {1'b0, s3_inter_ff} * best_u_ff;
      p_old    = {1'b0, best_i_ff} * s3_uni_ff;
      p_thr    = threshold * s3_uni_ff;
      inter_sh = {s3_inter_ff, 16'd0};
      take     = s3_vld_ff && (s3_uni_ff != 33'd0) && (p_new > p_old)
                 && ({2'b00, inter_sh} >= p_thr);
   end

   always_ff @(posedge clock) begin
      s1_idx_ff   <= cand_idx;
      s1_id_ff    <= cand.ident;
      s1_iw_ff    <= (x2 > x1) ? x2 - x1 : 17'd0;
      s1_ih_ff    <= (y2 > y1) ? y2 - y1 : 17'd0;
      s1_tw_ff    <= cand.width;
      s1_th_ff    <= cand.height;

      s2_idx_ff   <= s1_idx_ff;
      s2_id_ff    <= s1_id_ff;
      s2_inter_ff <= s1_iw_ff * s1_ih_ff;
      s2_at_ff    <= s1_tw_ff * s1_th_ff;
      s2_ab_ff    <= box_width * box_height;

      s3_idx_ff   <= s2_idx_ff;
      s3_id_ff    <= s2_id_ff;
      s3_inter_ff <= s2_inter_ff[31:0];
      s3_uni_ff   <= {1'b0, s2_ab_ff} + {1'b0, s2_at_ff} - {1'b0, s2_inter_ff[31:0]};

      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         s1_vld_ff <= cand_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         if (start) begin
            found_ff  <= 1'b0;
            best_i_ff <= 32'd0;
            best_u_ff <= 33'd1;
         end else if (take) begin
            found_ff    <= 1'b1;
            best_i_ff   <= s3_inter_ff;
            best_u_ff   <= s3_uni_ff;
            best_idx_ff <= s3_idx_ff;
            best_id_ff  <= s3_id_ff;
         end
      end
   end

   assign found      = found_ff;
   assign best_idx   = best_idx_ff;
   assign best_ident = best_id_ff;

endmodule

// File: sv/iou_greedy_box_tracker_core.sv
// Greedy IoU box tracker. Detection boxes arrive one transfer at a time on
// req_chan; each box with has_box set yields exactly one transfer on rsp_chan
// carrying the track id and whether that id is new. Tracks live in a chain of
// MAX_TRACKS cells that rotates past one IoU evaluator; each box is scored
// during one full rotation of the chain, followed by the drain of the
// evaluator's four-stage pipeline. An item with frame_end set adds an aging
// pass over the whole table, then moves the new boxes from the pending chain
// into the table, one per cycle, until they are all in or the table is full.
// Configuration writes on the csr_ port take effect at once and must only be
// issued while the block is idle with no result pending; out-of-range values load defaults.
module iou_greedy_box_tracker_core
   import iou_trk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   iou_trk_req_if.sink           req_chan,
   iou_trk_rsp_if.source         rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   seq_state_type state_ff, state_in;

   logic [16:0]          thr_ff, thr_in;
   logic [7:0]           miss_lim_ff, miss_lim_in;
   logic [SEQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TRK_CNT_W-1:0] wp_ff, wp_in;        // next free table slot while closing
   logic [PND_CNT_W-1:0] pcount_ff, pcount_in;
   logic [31:0]          next_id_ff, next_id_in;

   // latched item
   logic        has_box_ff, frame_end_ff;
   logic [15:0] bl_ff, bt_ff, bw_ff, bh_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_id_ff, rsp_id_in;
   logic        rsp_new_ff, rsp_new_in;

   trk_entry_type trk_q [MAX_TRACKS];
   cell_ctl_type  trk_ctl [MAX_TRACKS];
   trk_entry_type trk_tail_in, trk_wr_data;
   logic [TRK_IDX_W-1:0] trk_wr_idx;
   logic                 trk_wr, trk_shift;

   trk_entry_type pnd_q [MAX_BOXES_PER_FRAME];
   cell_ctl_type  pnd_ctl [MAX_BOXES_PER_FRAME];
   trk_entry_type pnd_wr_data, empty_entry;
   logic          pnd_wr, pnd_shift;

   logic                 ev_start, ev_found;
   logic [TRK_IDX_W-1:0] ev_best_idx;
   logic [31:0]          ev_best_id;
   logic                 scan_live;

   logic [8:0]           aged;
   logic [TRK_IDX_W:0]   age_pos;
   logic                 out_free;

   assign empty_entry = '0;
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign scan_live   = (state_ff == ST_SCAN) && (cnt_ff < SEQ_CNT_W'(MAX_TRACKS));

   // track chain: cell i takes cell i+1 on shift
   for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_trk
      always_comb begin
         trk_ctl[i].shift = trk_shift;
         trk_ctl[i].wr    = trk_wr && (trk_wr_idx == TRK_IDX_W'(i));
      end
      if (i == MAX_TRACKS - 1) begin : g_last
         iou_trk_cell u_cell (.clock, .reset, .ctl(trk_ctl[i]), .shift_in(trk_tail_in),
                              .wr_data(trk_wr_data), .entry(trk_q[i]));
      end else begin : g_mid
         iou_trk_cell u_cell (.clock, .reset, .ctl(trk_ctl[i]), .shift_in(trk_q[i+1]),
                              .wr_data(trk_wr_data), .entry(trk_q[i]));
      end
   end

   // pending chain: appended at pcount, drained from cell 0
   for (genvar i = 0; i < MAX_BOXES_PER_FRAME; i++) begin : g_pnd
      always_comb begin
         pnd_ctl[i].shift = pnd_shift;
         pnd_ctl[i].wr    = pnd_wr && (pcount_ff == PND_CNT_W'(i));
      end
      if (i == MAX_BOXES_PER_FRAME - 1) begin : g_last
         iou_trk_cell u_cell (.clock, .reset, .ctl(pnd_ctl[i]), .shift_in(empty_entry),
                              .wr_data(pnd_wr_data), .entry(pnd_q[i]));
      end else begin : g_mid
         iou_trk_cell u_cell (.clock, .reset, .ctl(pnd_ctl[i]), .shift_in(pnd_q[i+1]),
                              .wr_data(pnd_wr_data), .entry(pnd_q[i]));
      end
   end

   iou_trk_eval u_eval (
      .clock, .reset,
      .start      (ev_start),
      .cand_valid (scan_live && trk_q[0].valid && !trk_q[0].hit),
      .cand_idx   (cnt_ff[TRK_IDX_W-1:0]),
      .cand       (trk_q[0]),
      .box_left   (bl_ff),
      .box_top    (bt_ff),
      .box_width  (bw_ff),
      .box_height (bh_ff),
      .threshold  (thr_ff),
      .found      (ev_found),
      .best_idx   (ev_best_idx),
      .best_ident (ev_best_id)
   );

   // config
   always_comb begin
      thr_in      = thr_ff;
      miss_lim_in = miss_lim_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IOU_THRESHOLD: begin
               thr_in = (csr_wr_data != 17'd0 && csr_wr_data <= THR_ONE) ?
                        csr_wr_data : THR_DEFAULT;
            end
            CSR_MAX_MISSED: begin
               miss_lim_in = (csr_wr_data[7:0] != 8'd0) ? csr_wr_data[7:0] : MISS_DEFAULT;
            end
            default: ;
         endcase
      end
   end

   // aging of the head entry during the close pass
   always_comb begin
      aged    = trk_q[0].hit ? 9'd0 : {1'b0, trk_q[0].misses} + 9'd1;
      // a kept entry written here lands at wp after the remaining shifts
      age_pos = (TRK_IDX_W+1)'(wp_ff) + (TRK_IDX_W+1)'(MAX_TRACKS - 1)
                - (TRK_IDX_W+1)'(cnt_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      pcount_in    = pcount_ff;
      next_id_in   = next_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_new_in   = rsp_new_ff;
      req_chan.ready = 1'b0;
      ev_start     = 1'b0;
      trk_shift    = 1'b0;
      trk_wr       = 1'b0;
      trk_wr_idx   = '0;
      trk_tail_in  = trk_q[0];
      trk_wr_data  = '0;
      pnd_shift    = 1'b0;
      pnd_wr       = 1'b0;
      pnd_wr_data  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            cnt_in = '0;
            wp_in  = '0;
            if (req_chan.valid) begin
               ev_start = 1'b1;
               if (req_chan.has_box) begin
                  state_in = ST_SCAN;
               end else if (req_chan.frame_end) begin
                  state_in = ST_AGE;
               end
            end
         end
         ST_SCAN: begin
            trk_shift = scan_live;       // ring rotates once, back to start order
            cnt_in    = cnt_ff + SEQ_CNT_W'(1);
            if (cnt_ff == SEQ_CNT_W'(SCAN_LEN - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (ev_found) begin
                  rsp_id_in  = ev_best_id;
                  rsp_new_in = 1'b0;
                  trk_wr     = 1'b1;
                  trk_wr_idx = ev_best_idx;
                  trk_wr_data = '{valid: 1'b1, hit: 1'b1, misses: 8'd0, ident: ev_best_id,
                                  left: bl_ff, top: bt_ff, width: bw_ff, height: bh_ff};
               end else begin
                  rsp_id_in  = next_id_ff;
                  rsp_new_in = 1'b1;
                  next_id_in = next_id_ff + 32'd1;
                  if (pcount_ff < PND_CNT_W'(MAX_BOXES_PER_FRAME)) begin
                     pnd_wr      = 1'b1;
                     pcount_in   = pcount_ff + PND_CNT_W'(1);
                     pnd_wr_data = '{valid: 1'b1, hit: 1'b0, misses: 8'd0, ident: next_id_ff,
                                     left: bl_ff, top: bt_ff, width: bw_ff, height: bh_ff};
                  end
               end
               cnt_in   = '0;
               state_in = frame_end_ff ? ST_AGE : ST_IDLE;
            end
         end
         ST_AGE: begin
            // pop head each cycle; survivors are written back compacted
            trk_shift   = 1'b1;
            trk_tail_in = empty_entry;
            if (trk_q[0].valid && aged <= {1'b0, miss_lim_ff}) begin
               trk_wr      = 1'b1;
               trk_wr_idx  = age_pos[TRK_IDX_W-1:0];
               trk_wr_data = trk_q[0];
               trk_wr_data.hit    = 1'b0;
               trk_wr_data.misses = aged[7:0];
               wp_in = wp_ff + TRK_CNT_W'(1);
            end
            cnt_in = cnt_ff + SEQ_CNT_W'(1);
            if (cnt_ff == SEQ_CNT_W'(MAX_TRACKS - 1)) begin
               cnt_in   = '0;
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (cnt_ff == SEQ_CNT_W'(pcount_ff) || wp_ff == TRK_CNT_W'(MAX_TRACKS)) begin
               pcount_in = '0;
               state_in  = ST_IDLE;
            end else begin
               trk_wr      = 1'b1;
               trk_wr_idx  = wp_ff[TRK_IDX_W-1:0];
               trk_wr_data = pnd_q[0];
               trk_wr_data.valid  = 1'b1;
               trk_wr_data.hit    = 1'b0;
               trk_wr_data.misses = 8'd0;
               pnd_shift = 1'b1;
               wp_in     = wp_ff + TRK_CNT_W'(1);
               cnt_in    = cnt_ff + SEQ_CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_DEFAULT;
         miss_lim_ff  <= MISS_DEFAULT;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         pcount_ff    <= '0;
         next_id_ff   <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         miss_lim_ff  <= miss_lim_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         pcount_ff    <= pcount_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff  <= rsp_id_in;
      rsp_new_ff <= rsp_new_in;
      if (state_ff == ST_IDLE && req_chan.valid) begin
         has_box_ff   <= req_chan.has_box;
         frame_end_ff <= req_chan.frame_end;
         bl_ff        <= req_chan.box_left;
         bt_ff        <= req_chan.box_top;
         bw_ff        <= req_chan.box_width;
         bh_ff        <= req_chan.box_height;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff && (has_box_ff || !has_box_ff);
   assign rsp_chan.face_id   = rsp_id_ff;
   assign rsp_chan.new_track = rsp_new_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import iou_trk_pkg::*;

   localparam int  LIMIT_CYCLES = 3_000_000;
   // aging pass + append pass + one scan, with margin
   localparam int  SETTLE_CYCLES = 4 * (MAX_TRACKS + MAX_BOXES_PER_FRAME + SCAN_LEN);

   typedef struct {
      bit        has_box;
      bit [15:0] left;
      bit [15:0] top;
      bit [15:0] width;
      bit [15:0] height;
      bit        frame_end;
   } det_item_type;

   typedef struct {
      bit [31:0] face_id;
      bit        new_track;
   } track_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   iou_trk_req_if req_chan ();
   iou_trk_rsp_if rsp_chan ();

   iou_greedy_box_tracker_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor state: its own copy of the track table and registers
   // ---------------------------------------------------------------
   bit [16:0] pr_threshold;
   bit [7:0]  pr_miss_limit;
   bit [15:0] tk_left [MAX_TRACKS];
   bit [15:0] tk_top [MAX_TRACKS];
   bit [15:0] tk_width [MAX_TRACKS];
   bit [15:0] tk_height [MAX_TRACKS];
   bit [31:0] tk_ident [MAX_TRACKS];
   bit [7:0]  tk_misses [MAX_TRACKS];
   bit        tk_hit [MAX_TRACKS];
   int        tk_count;
   bit [63:0] pd_box [MAX_BOXES_PER_FRAME];
   bit [31:0] pd_ident [MAX_BOXES_PER_FRAME];
   int        pd_count;
   bit [31:0] ident_next;

   det_item_type  pending_items [$];
   track_rsp_type expected_ids [$];
   int         error_count = 0;
   int         cycle_count = 0;
   bit         no_idle = 1'b0;
   bit         hold_req = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Intersection and union areas of a detection and a stored track.
   function automatic void box_overlap(input bit [15:0] l1, t1, w1, h1,
                                       input bit [15:0] l2, t2, w2, h2,
                                       output bit [63:0] inter, output bit [63:0] uni);
      bit [31:0] x1, y1, x2, y2, r1, r2, b1, b2;
      bit [63:0] iw, ih;
      x1 = (l1 > l2) ? 32'(l1) : 32'(l2);
      y1 = (t1 > t2) ? 32'(t1) : 32'(t2);
      r1 = 32'(l1) + 32'(w1); r2 = 32'(l2) + 32'(w2);
      b1 = 32'(t1) + 32'(h1); b2 = 32'(t2) + 32'(h2);
      x2 = (r1 < r2) ? r1 : r2;
      y2 = (b1 < b2) ? b1 : b2;
      iw = (x2 > x1) ? 64'(x2 - x1) : 64'd0;
      ih = (y2 > y1) ? 64'(y2 - y1) : 64'd0;
      inter = iw * ih;
      uni = 64'(w1) * 64'(h1) + 64'(w2) * 64'(h2) - inter;
   endfunction

   // Ages unmatched tracks, drops stale ones, compacts, appends new boxes.
   function automatic void close_frame_model();
      int k;
      bit [8:0] m;
      k = 0;
      for (int j = 0; j < tk_count; j++) begin
         m = tk_hit[j] ? 9'd0 : 9'(tk_misses[j]) + 9'd1;
         tk_hit[j] = 1'b0;
         if (m > 9'(pr_miss_limit)) continue;
         tk_left[k] = tk_left[j];   tk_top[k] = tk_top[j];
         tk_width[k] = tk_width[j]; tk_height[k] = tk_height[j];
         tk_ident[k] = tk_ident[j]; tk_misses[k] = m[7:0];
         k++;
      end
      for (int p = 0; p < pd_count; p++) begin
         if (k >= MAX_TRACKS) break;
         {tk_height[k], tk_width[k], tk_top[k], tk_left[k]} = pd_box[p];
         tk_ident[k] = pd_ident[p];
         tk_misses[k] = 8'd0;
         tk_hit[k] = 1'b0;
         k++;
      end
      tk_count = k;
      pd_count = 0;
   endfunction

   // Greedy match of one accepted detection; queues the id it must get.
   function automatic void track_detection(input det_item_type it);
      bit [63:0]  inter, uni, best_i, best_u;
      bit [127:0] lhs, rhs;
      int         best;
      bit         found;
      track_rsp_type r;
      if (it.has_box) begin
         best_i = 64'd0; best_u = 64'd1; best = 0; found = 1'b0;
         for (int j = 0; j < tk_count; j++) begin
            if (tk_hit[j]) continue;
            box_overlap(it.left, it.top, it.width, it.height,
                        tk_left[j], tk_top[j], tk_width[j], tk_height[j], inter, uni);
            if (uni == 64'd0) continue;
            lhs = 128'(inter) * 128'(best_u);
            rhs = 128'(best_i) * 128'(uni);
            if (!(lhs > rhs)) continue;
            if (inter * 64'd65536 < 64'(pr_threshold) * uni) continue;
            best_i = inter; best_u = uni; best = j; found = 1'b1;
         end
         if (found) begin
            tk_left[best] = it.left;   tk_top[best] = it.top;
            tk_width[best] = it.width; tk_height[best] = it.height;
            tk_misses[best] = 8'd0;
            tk_hit[best] = 1'b1;
            r.face_id = tk_ident[best];
            r.new_track = 1'b0;
         end else begin
            r.face_id = ident_next;
            r.new_track = 1'b1;
            ident_next = ident_next + 32'd1;
            if (pd_count < MAX_BOXES_PER_FRAME) begin
               pd_box[pd_count] = {it.height, it.width, it.top, it.left};
               pd_ident[pd_count] = r.face_id;
               pd_count++;
            end
         end
         expected_ids.push_back(r);
      end
      if (it.frame_end) close_frame_model();
   endfunction

   // ---------------------------------------------------------------
   // Driver: one transfer per pending item, random idle cycles
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      det_item_type cur, nxt;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.has_box    <= 1'b0;
         req_chan.box_left   <= '0;
         req_chan.box_top    <= '0;
         req_chan.box_width  <= '0;
         req_chan.box_height <= '0;
         req_chan.frame_end  <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            cur.has_box = req_chan.has_box;    cur.left = req_chan.box_left;
            cur.top = req_chan.box_top;        cur.width = req_chan.box_width;
            cur.height = req_chan.box_height;  cur.frame_end = req_chan.frame_end;
            track_detection(cur);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_items.size() > 0 && !hold_req &&
                (no_idle || $urandom_range(99) >= 31)) begin
               nxt = pending_items.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.has_box    <= nxt.has_box;
               req_chan.box_left   <= nxt.left;
               req_chan.box_top    <= nxt.top;
               req_chan.box_width  <= nxt.width;
               req_chan.box_height <= nxt.height;
               req_chan.frame_end  <= nxt.frame_end;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random backpressure, compare each transfer in order
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      track_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= no_idle || ($urandom_range(99) >= 31);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_ids.size() == 0) begin
               report_mismatch($sformatf("unexpected result id=%0d new=%0b",
                                         rsp_chan.face_id, rsp_chan.new_track));
            end else begin
               want = expected_ids.pop_front();
               if (rsp_chan.face_id !== want.face_id)
                  report_mismatch($sformatf("face_id got %0d want %0d",
                                            rsp_chan.face_id, want.face_id));
               if (rsp_chan.new_track !== want.new_track)
                  report_mismatch($sformatf("new_track got %0b want %0b (id %0d)",
                                            rsp_chan.new_track, want.new_track,
                                            want.face_id));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic add_item(input bit hb, input bit [15:0] l, t, w, h, input bit fe);
      det_item_type it;
      it.has_box = hb; it.left = l; it.top = t; it.width = w; it.height = h;
      it.frame_end = fe;
      pending_items.push_back(it);
   endtask

   // Lets every queued item go, then waits out the tail of the last frame.
   task automatic drain();
      while (pending_items.size() > 0 || req_chan.valid || expected_ids.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; the model takes the new value when the write is driven, before the block registers it.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input bit [16:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wr_data <= val;
      if (idx == CSR_IOU_THRESHOLD)
         pr_threshold = (val >= 17'd1 && val <= THR_ONE) ? val : THR_DEFAULT;
      else if (idx == CSR_MAX_MISSED)
         pr_miss_limit = (val[7:0] != 8'd0) ? val[7:0] : MISS_DEFAULT;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Frames built around a small scene of moving objects, plus noise.
   task automatic random_frames(input int n_items);
      bit [15:0] sl [8], st [8], sw [8], sh [8];
      int done, nf, k, sel;
      bit [15:0] l, t, w, h;
      for (int i = 0; i < 8; i++) begin
         sl[i] = 16'($urandom_range(60000)); st[i] = 16'($urandom_range(60000));
         sw[i] = 16'($urandom_range(4, 3000)); sh[i] = 16'($urandom_range(4, 3000));
      end
      done = 0;
      while (done < n_items) begin
         nf = $urandom_range(1, 9);
         for (k = 0; k < nf; k++) begin
            sel = $urandom_range(99);
            if (sel < 75) begin
               int o;
               o = $urandom_range(7);
               sl[o] = sl[o] + 16'($urandom_range(8)) - 16'd4;
               st[o] = st[o] + 16'($urandom_range(8)) - 16'd4;
               l = sl[o]; t = st[o];
               w = sw[o] + 16'($urandom_range(6)) - 16'd3;
               h = sh[o] + 16'($urandom_range(6)) - 16'd3;
            end else if (sel < 90) begin
               l = 16'($urandom); t = 16'($urandom); w = 16'($urandom); h = 16'($urandom);
            end else begin
               l = 16'($urandom); t = 16'($urandom);
               w = ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom);
               h = 16'($urandom);
            end
            add_item($urandom_range(99) >= 8, l, t, w, h, k == nf - 1);
            done++;
         end
      end
   endtask

   initial begin
      pr_threshold = THR_DEFAULT;
      pr_miss_limit = MISS_DEFAULT;
      tk_count = 0; pd_count = 0; ident_next = 32'd0;
      foreach (tk_hit[i]) tk_hit[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, zero area, empty items, exact match.
      add_item(1'b1, 16'd100, 16'd100, 16'd50, 16'd50, 1'b0);
      add_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);   // ignored
      add_item(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);               // zero area
      add_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      add_item(1'b1, 16'd100, 16'd100, 16'd50, 16'd50, 1'b0);         // exact match
      add_item(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);               // zero area never matches
      add_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_item(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);               // empty frame close
      add_item(1'b1, 16'd105, 16'd102, 16'd50, 16'd50, 1'b1);
      add_item(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      drain();

      // Pending overflow in one frame, then a full table drops new boxes.
      for (int i = 0; i < MAX_BOXES_PER_FRAME + 3; i++)
         add_item(1'b1, 16'(i * 1000), 16'd0, 16'd10, 16'd10, i == MAX_BOXES_PER_FRAME + 2);
      for (int i = 0; i < 4; i++)
         add_item(1'b1, 16'(i * 1000), 16'd30000, 16'd10, 16'd10, i == 3);
      drain();

      // Threshold extremes and out-of-range loads; stray indexes ignored.
      csr_write(CSR_IOU_THRESHOLD, 17'd1);
      csr_write(CSR_MAX_MISSED, 17'd1);
      csr_write(2'd2, 17'h1FFFF);
      csr_write(2'd3, 17'h0AAAA);
      random_frames(250);
      drain();
      csr_write(CSR_IOU_THRESHOLD, THR_ONE);
      csr_write(CSR_MAX_MISSED, 17'd0);                         // loads default
      no_idle = 1'b1;                                           // stretch at full rate
      random_frames(250);
      drain();
      no_idle = 1'b0;
      csr_write(CSR_IOU_THRESHOLD, 17'd0);                      // loads default
      csr_write(CSR_MAX_MISSED, 17'd255);
      random_frames(250);
      // a track survives 255 misses, goes at the 256th
      add_item(1'b1, 16'd5000, 16'd5000, 16'd300, 16'd300, 1'b1);
      for (int i = 0; i < 258; i++) add_item(1'b0, 16'($urandom), 16'($urandom),
                                             16'($urandom), 16'($urandom), 1'b1);
      add_item(1'b1, 16'd5000, 16'd5000, 16'd300, 16'd300, 1'b1);
      drain();
      csr_write(CSR_IOU_THRESHOLD, 17'h1FFFF);                  // above 1.0, default
      csr_write(CSR_MAX_MISSED, 17'h1FF00);                     // low byte zero, default
      random_frames(250);
      // sender holds off until every result is back, mid phase
      hold_req = 1'b1;
      while (req_chan.valid || expected_ids.size() > 0) @(posedge clock);
      hold_req = 1'b0;
      random_frames(100);
      drain();
      csr_write(CSR_IOU_THRESHOLD, 17'($urandom_range(1, 65536)));
      csr_write(CSR_MAX_MISSED, 17'($urandom_range(1, 255)));
      random_frames(100);
      drain();

      if (error_count == 0 && expected_ids.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (expected_ids.size() > 0)
            $display("%0d results never arrived", expected_ids.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
